FILE: sv/tbd_pkg.sv
package tbd_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned BlockWidth = 2 * WordWidth;
   localparam int unsigned RoundCount = 16;
   localparam int unsigned HalfRoundCount = 2 * RoundCount;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [WordWidth-1:0] SumStart = 32'hE377_9B90;
   localparam logic [WordWidth-1:0] DeltaStep = 32'h61C8_8647;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type KeyIdx0 = 2'd0;
   localparam csr_index_type KeyIdx1 = 2'd1;
   localparam csr_index_type KeyIdx2 = 2'd2;
   localparam csr_index_type KeyIdx3 = 2'd3;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      logic     valid;
      word_type left;
      word_type right;
   } stage_type;

   typedef struct packed {
      word_type k0;
      word_type k1;
      word_type k2;
      word_type k3;
   } key_type;

   function automatic word_type tbd_mix(input word_type v, input word_type ka,
                                        input word_type kb, input word_type sum);
      tbd_mix = ((v >> 5) + kb) ^ ((v << 4) + ka) ^ (sum + v);
   endfunction

   function automatic word_type round_sum(input int unsigned round_idx);
      round_sum = SumStart + word_type'(round_idx) * DeltaStep;
   endfunction

endpackage

FILE: sv/tbd_half_round.sv
module tbd_half_round #(
   parameter bit UpdateRight = 1'b1,
   parameter logic [31:0] RoundSum = 32'h0
) (
   input  logic               clock,
   input  logic               reset,
   input  tbd_pkg::key_type   key,
   input  tbd_pkg::stage_type stage_in,
   output tbd_pkg::stage_type stage_out
);
   import tbd_pkg::*;

   logic     valid_ff;
   word_type left_ff;
   word_type left_in;
   word_type right_ff;
   word_type right_in;

   always_comb begin
      left_in = stage_in.left;
      right_in = stage_in.right;
      if (UpdateRight) begin
         right_in = stage_in.right - tbd_mix(stage_in.left, key.k2, key.k3, RoundSum);
      end else begin
         left_in = stage_in.left - tbd_mix(stage_in.right, key.k0, key.k1, RoundSum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      right_ff <= right_in;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.left = left_ff;
   assign stage_out.right = right_ff;

endmodule

FILE: sv/tea_block_decipher_16_round.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+----------------------------------
// request   | start, busy, req_cipher_block           | taken when start high, busy low
// response  | rsp_valid, rsp_plain_block              | one-cycle strobe, never held off
// csr       | psel penable pwrite paddr pwdata prdata | APB read and write, key words at 0x0..0xC
//
// One half-round per register stage, 32 stages; a block enters every cycle.
// busy stays low: the pipeline always advances and the receiver cannot stall.
// Synchronous reset clears the stage valid bits and the key words.
// Change the key words only while no transaction is in flight.
module tea_block_decipher_16_round (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [tbd_pkg::BlockWidth-1:0]  req_cipher_block,
   output logic                            rsp_valid,
   output logic [tbd_pkg::BlockWidth-1:0]  rsp_plain_block,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tbd_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [tbd_pkg::WordWidth-1:0]   pwdata,
   output logic [tbd_pkg::WordWidth-1:0]   prdata,
   output logic                            pready
);
   import tbd_pkg::*;

   key_type       key_ff;
   key_type       key_in;
   csr_index_type csr_index;
   logic          csr_write;
   stage_type     stage [0:HalfRoundCount];

   assign busy = 1'b0;
   assign pready = 1'b1;
   assign csr_index = paddr[CsrAddrWidth-1:CsrAddrWidth-CsrIndexWidth];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         unique case (csr_index)
            KeyIdx0: key_in.k0 = pwdata;
            KeyIdx1: key_in.k1 = pwdata;
            KeyIdx2: key_in.k2 = pwdata;
            KeyIdx3: key_in.k3 = pwdata;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         KeyIdx0: prdata = key_ff.k0;
         KeyIdx1: prdata = key_ff.k1;
         KeyIdx2: prdata = key_ff.k2;
         KeyIdx3: prdata = key_ff.k3;
         default: prdata = '0;
      endcase
   end

   assign stage[0].valid = start && !busy;
   assign stage[0].left = req_cipher_block[BlockWidth-1:WordWidth];
   assign stage[0].right = req_cipher_block[WordWidth-1:0];

   for (genvar g = 0; g < HalfRoundCount; g++) begin : g_half
      tbd_half_round #(
         .UpdateRight ((g % 2) == 0),
         .RoundSum    (round_sum(g / 2))
      ) u_half_round (
         .clock     (clock),
         .reset     (reset),
         .key       (key_ff),
         .stage_in  (stage[g]),
         .stage_out (stage[g+1])
      );
   end

   assign rsp_valid = stage[HalfRoundCount].valid;
   assign rsp_plain_block = {stage[HalfRoundCount].left, stage[HalfRoundCount].right};

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(HalfRoundCount) rsp_valid)
      else $error("accepted transaction produced no response");

   a_no_phantom_result: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##(HalfRoundCount) !rsp_valid)
      else $error("response without an accepted transaction");

   a_key0_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == KeyIdx0) |=> key_ff.k0 == $past(pwdata))
      else $error("key word 0 write lost");

   a_key_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> $stable(key_ff))
      else $error("key words changed without a write");

endmodule
